>>> hw/rtl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache package
// Shared sizes, beat payload types and the control structs that travel
// between the sequencer, the scan unit and the entry store.
// ----------------------------------------------------------------------------
package lfu_pkg;

   // Sizing
   localparam int ENTRIES    = 16;
   localparam int COUNT_BITS = 16;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = IDX_W;
   localparam int OCC_W = $clog2(ENTRIES + 1);
   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CSR_W = 5;
   localparam int CMP_W = (OCC_W > CSR_W) ? OCC_W : CSR_W;

   localparam logic [CSR_W-1:0]      CAP_RESET = CSR_W'(16);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);
   localparam logic [VAL_W-1:0]      MISS_VALUE = {VAL_W{1'b1}};
   localparam logic [VAL_W-1:0]      PUT_VALUE = '0;

   // Operation codes carried in the request beat
   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   // Request and response beats
   typedef struct packed {
      logic                    kind;
      logic signed [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                    found;
      logic signed [VAL_W-1:0] read_value;
   } rsp_type;

   // One entry as read from the store
   typedef struct packed {
      logic                  valid;
      logic [KEY_W-1:0]      key;
      logic [VAL_W-1:0]      value;
      logic [COUNT_BITS-1:0] count;
      logic [RANK_W-1:0]     rank;
   } entry_type;

   // Outcome of one pass over the entries
   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      logic [RANK_W-1:0] hit_rank;
      logic [VAL_W-1:0]  hit_value;
      logic              victim_ok;
      logic [IDX_W-1:0]  victim_idx;
      logic [RANK_W-1:0] victim_rank;
      logic              free_ok;
      logic [IDX_W-1:0]  free_idx;
   } scan_type;

   // Store update command
   typedef enum logic [1:0] {
      UPD_NONE   = 2'b00,
      UPD_HIT    = 2'b01,
      UPD_INSERT = 2'b10
   } upd_op_type;

   typedef struct packed {
      upd_op_type        op;
      logic [IDX_W-1:0]  idx;
      logic [RANK_W-1:0] hit_rank;
      logic              put;
      logic [KEY_W-1:0]  key;
      logic [VAL_W-1:0]  value;
      logic              evict;
      logic [RANK_W-1:0] victim_rank;
   } upd_type;

endpackage

>>> hw/rtl/lfu_store.sv
// ----------------------------------------------------------------------------
// LFU entry store
// Entry registers with one read port at the scan index and an update that
// applies a hit or an insert across all entries in parallel.
// ----------------------------------------------------------------------------
module lfu_store
   import lfu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] rd_idx,
   output entry_type        rd,
   input  upd_type          upd
);

   logic [ENTRIES-1:0]    valid_ff;
   logic [ENTRIES-1:0]    valid_in;
   logic [KEY_W-1:0]      key_ff   [ENTRIES];
   logic [KEY_W-1:0]      key_in   [ENTRIES];
   logic [VAL_W-1:0]      value_ff [ENTRIES];
   logic [VAL_W-1:0]      value_in [ENTRIES];
   logic [COUNT_BITS-1:0] count_ff [ENTRIES];
   logic [COUNT_BITS-1:0] count_in [ENTRIES];
   logic [RANK_W-1:0]     rank_ff  [ENTRIES];
   logic [RANK_W-1:0]     rank_in  [ENTRIES];

   // Read the entry under the scan index
   assign rd.valid = valid_ff[rd_idx];
   assign rd.key   = key_ff[rd_idx];
   assign rd.value = value_ff[rd_idx];
   assign rd.count = count_ff[rd_idx];
   assign rd.rank  = rank_ff[rd_idx];

   // Apply the update command to every entry in parallel
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      count_in = count_ff;
      rank_in  = rank_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         case (upd.op)
            UPD_HIT: begin
               // age entries newer than the hit one, then make it the newest
               if (valid_ff[i] && (rank_ff[i] < upd.hit_rank)) begin
                  rank_in[i] = rank_ff[i] + 1'b1;
               end
               if (IDX_W'(i) == upd.idx) begin
                  rank_in[i] = '0;
                  if (count_ff[i] != COUNT_MAX) begin
                     count_in[i] = count_ff[i] + 1'b1;
                  end
                  if (upd.put) begin
                     value_in[i] = upd.value;
                  end
               end
            end
            UPD_INSERT: begin
               if (IDX_W'(i) == upd.idx) begin
                  valid_in[i] = 1'b1;
                  key_in[i]   = upd.key;
                  value_in[i] = upd.value;
                  count_in[i] = COUNT_ONE;
                  rank_in[i]  = '0;
               end else if (valid_ff[i]) begin
                  // close the gap left by the victim, then age by one
                  if (upd.evict && (rank_ff[i] > upd.victim_rank)) begin
                     rank_in[i] = rank_ff[i];
                  end else begin
                     rank_in[i] = rank_ff[i] + 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Valid bits clear on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Entry payload
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      count_ff <= count_in;
      rank_ff  <= rank_in;
   end

endmodule

>>> hw/rtl/lfu_scan.sv
// ----------------------------------------------------------------------------
// LFU scan unit
// Shared compare unit, one entry per cycle while step is high: finds the key
// match, the eviction victim (lowest count, oldest on a tie), first free slot.
// ----------------------------------------------------------------------------
module lfu_scan
   import lfu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             step,
   input  logic [IDX_W-1:0] idx,
   input  entry_type        rd,
   input  logic [KEY_W-1:0] key,
   output scan_type         result
);

   scan_type              res_ff;
   scan_type              res_in;
   logic [COUNT_BITS-1:0] vcount_ff;
   logic [COUNT_BITS-1:0] vcount_in;
   logic                  take_victim;

   // Victim test: lower count wins, equal count goes to the older entry
   assign take_victim = !res_ff.victim_ok || (rd.count < vcount_ff) ||
                        ((rd.count == vcount_ff) && (rd.rank > res_ff.victim_rank));

   // Clear the trackers, or advance them by one entry
   always_comb begin
      res_in    = res_ff;
      vcount_in = vcount_ff;
      if (clear) begin
         res_in = '0;
      end else if (step) begin
         if (rd.valid) begin
            if (!res_ff.hit && (rd.key == key)) begin
               res_in.hit       = 1'b1;
               res_in.hit_idx   = idx;
               res_in.hit_rank  = rd.rank;
               res_in.hit_value = rd.value;
            end
            if (take_victim) begin
               res_in.victim_ok   = 1'b1;
               res_in.victim_idx  = idx;
               res_in.victim_rank = rd.rank;
               vcount_in          = rd.count;
            end
         end else if (!res_ff.free_ok) begin
            res_in.free_ok  = 1'b1;
            res_in.free_idx = idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      vcount_ff <= vcount_in;
   end

   assign result = res_ff;

endmodule

>>> hw/rtl/lfu_cache_lru_tiebreak_core.sv
// ----------------------------------------------------------------------------
// LFU cache with LRU tie-break
// Fully associative key-value cache; evicts the least used entry, oldest
// first among equal counts.
//
//  Channel  Direction  Handshake           Beat
//  req_     in         req_valid/req_stall req_data (kind, key, write_value)
//  rsp_     out        rsp_valid/rsp_stall rsp_data (found, read_value)
//  csr_     in         csr_valid/csr_ready csr_data (capacity_in_use)
//
// An item passes from acceptance through a scan of every entry in turn
// through the shared compare unit, then an update and the load of the
// response register; with capacity zero it goes straight to the response.
// req_stall is high from acceptance until the response is loaded; a stalled
// response holds the block in its last step. Reset is synchronous and clears
// all valid bits at once; capacity resets to 16.
// ----------------------------------------------------------------------------
module lfu_cache_lru_tiebreak_core
   import lfu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic [OCC_W-1:0] occ_ff;
   logic [OCC_W-1:0] occ_in;
   logic [CSR_W-1:0] cap_ff;
   logic             cap0_ff;
   logic             cap0_in;
   req_type          req_ff;
   req_type          req_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   logic             req_take;
   logic             rsp_free;
   logic             full;
   logic             is_put;
   entry_type        rd;
   scan_type         scan;
   upd_type          upd;

   assign req_take  = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign is_put    = (req_ff.kind == KIND_PUT);
   assign csr_ready = 1'b1;

   // Full when occupancy reaches the capacity, clamped to the entry count
   assign full = (CMP_W'(occ_ff) >= CMP_W'(cap_ff)) || (occ_ff == OCC_W'(ENTRIES));

   lfu_store u_store (
      .clock  (clock),
      .reset  (reset),
      .rd_idx (idx_ff),
      .rd     (rd),
      .upd    (upd)
   );

   lfu_scan u_scan (
      .clock  (clock),
      .reset  (reset),
      .clear  (req_take),
      .step   (state_ff == ST_SCAN),
      .idx    (idx_ff),
      .rd     (rd),
      .key    (req_ff.key),
      .result (scan)
   );

   // Build the store update from the scan outcome
   always_comb begin
      upd             = '0;
      upd.op          = UPD_NONE;
      upd.hit_rank    = scan.hit_rank;
      upd.put         = is_put;
      upd.key         = req_ff.key;
      upd.value       = req_ff.write_value;
      upd.evict       = full;
      upd.victim_rank = scan.victim_rank;
      if (scan.hit) begin
         upd.idx = scan.hit_idx;
      end else if (full) begin
         upd.idx = scan.victim_idx;
      end else begin
         upd.idx = scan.free_idx;
      end
      if (state_ff == ST_UPDATE) begin
         if (scan.hit) begin
            upd.op = UPD_HIT;
         end else if (is_put) begin
            upd.op = UPD_INSERT;
         end
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      occ_in       = occ_ff;
      cap0_in      = cap0_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               req_in  = req_data;
               cap0_in = (cap_ff == '0);
               idx_in  = '0;
               state_in = (cap_ff == '0) ? ST_EMIT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (idx_ff == IDX_W'(ENTRIES - 1)) begin
               idx_in   = '0;
               state_in = ST_UPDATE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            // an insert adds one entry; an eviction drops one first
            if (!scan.hit && is_put && !full) begin
               occ_in = occ_ff + 1'b1;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_in.found = !cap0_ff && scan.hit;
               if (is_put) begin
                  rsp_in.read_value = PUT_VALUE;
               end else if (!cap0_ff && scan.hit) begin
                  rsp_in.read_value = scan.hit_value;
               end else begin
                  rsp_in.read_value = MISS_VALUE;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         occ_ff       <= '0;
         cap_ff       <= CAP_RESET;
         cap0_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         occ_ff       <= occ_in;
         cap0_ff      <= cap0_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            cap_ff <= csr_data;
         end
      end
   end

   // Request and response beats
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
